// ----- rtl/core/twn_pkg.sv -----
`default_nettype none

package twn_pkg;

  localparam int VALUE_BITS         = 32;
  localparam int FRACTION_BITS_DEF  = 16;
  localparam int CMD_W              = 3;
  localparam int DELTA_W            = 16;
  localparam int SPAN_W             = 24;
  localparam int REPEAT_W           = 17;
  localparam int ELAPSED_W          = 26;
  localparam int PASS_W             = 16;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_W              = (VALUE_BITS > SPAN_W) ? VALUE_BITS : SPAN_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_PAUSE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_VALUE  = 3'd0,
    CFG_END_VALUE    = 3'd1,
    CFG_SPAN_MS      = 3'd2,
    CFG_LEAD_MS      = 3'd3,
    CFG_REPEAT_LIMIT = 3'd4,
    CFG_YOYO_ENABLE  = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_LEAD,
    C_SPAN,
    C_WAIT
  } ctl_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_DIFF,
    U_DIV,
    U_TSEL,
    U_MUL,
    U_ADD,
    U_DONE
  } arith_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [DELTA_W-1:0] delta_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] current_value;
    logic                         value_updated;
    logic                         still_active;
    logic [1:0]                   run_state;
    logic                         just_finished;
  } out_item_t;

  typedef struct packed {
    logic                         go;
    logic [SPAN_W-1:0]            active;
    logic [SPAN_W-1:0]            span;
    logic                         rev;
    logic signed [VALUE_BITS-1:0] start_value;
    logic signed [VALUE_BITS-1:0] end_value;
  } arith_req_t;

  typedef struct packed {
    logic                         done;
    logic signed [VALUE_BITS-1:0] value;
  } arith_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/twn_arith.sv -----
`default_nettype none

module twn_arith
  import twn_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  arith_req_t req,
  output arith_rsp_t rsp
);

  localparam int DW = VALUE_BITS + 1;
  localparam int PW = DW + FRACTION_BITS;
  localparam int AW = PW + 1;
  localparam int RW = SPAN_W + 1;
  localparam int CW = $clog2(FRACTION_BITS + 1);

  arith_state_t state_r, state_nxt;
  logic [RW-1:0]                rem_r, rem_nxt;
  logic [SPAN_W-1:0]            span_r, span_nxt;
  logic [FRACTION_BITS-1:0]     q_r, q_nxt;
  logic [PW-1:0]                acc_r, acc_nxt;
  logic [DW-1:0]                diff_r, diff_nxt;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic signed [VALUE_BITS-1:0] sv_r, sv_nxt;
  logic signed [VALUE_BITS-1:0] ev_r, ev_nxt;
  logic                         rev_r, rev_nxt;
  logic signed [VALUE_BITS-1:0] value_r, value_nxt;

  logic [AW-1:0] op_a, op_b, sum;
  logic          sub;
  logic [RW-1:0] rem2;
  logic          ge;

  assign rem2 = {rem_r[RW-2:0], 1'b0};
  assign sum  = op_a + (sub ? ~op_b : op_b) + {{(AW-1){1'b0}}, sub};
  assign ge   = ~sum[AW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rem_r   <= rem_nxt;
    span_r  <= span_nxt;
    q_r     <= q_nxt;
    acc_r   <= acc_nxt;
    diff_r  <= diff_nxt;
    cnt_r   <= cnt_nxt;
    sv_r    <= sv_nxt;
    ev_r    <= ev_nxt;
    rev_r   <= rev_nxt;
    value_r <= value_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    span_nxt  = span_r;
    q_nxt     = q_r;
    acc_nxt   = acc_r;
    diff_nxt  = diff_r;
    cnt_nxt   = cnt_r;
    sv_nxt    = sv_r;
    ev_nxt    = ev_r;
    rev_nxt   = rev_r;
    value_nxt = value_r;
    op_a      = '0;
    op_b      = '0;
    sub       = 1'b0;

    unique case (state_r)
      U_IDLE: begin
        if (req.go) begin
          rem_nxt   = {1'b0, req.active};
          span_nxt  = req.span;
          rev_nxt   = req.rev;
          sv_nxt    = req.start_value;
          ev_nxt    = req.end_value;
          q_nxt     = '0;
          cnt_nxt   = CW'(FRACTION_BITS);
          state_nxt = U_DIFF;
        end
      end
      U_DIFF: begin
        op_a      = {{(AW-VALUE_BITS){ev_r[VALUE_BITS-1]}}, ev_r};
        op_b      = {{(AW-VALUE_BITS){sv_r[VALUE_BITS-1]}}, sv_r};
        sub       = 1'b1;
        diff_nxt  = sum[DW-1:0];
        state_nxt = U_DIV;
      end
      U_DIV: begin
        op_a    = {{(AW-RW){1'b0}}, rem2};
        op_b    = {{(AW-SPAN_W){1'b0}}, span_r};
        sub     = 1'b1;
        rem_nxt = ge ? sum[RW-1:0] : rem2;
        q_nxt   = {q_r[FRACTION_BITS-2:0], ge};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = U_TSEL;
        end
      end
      U_TSEL: begin
        if (rev_r && (q_r == '0)) begin
          value_nxt = ev_r;
          state_nxt = U_DONE;
        end else begin
          q_nxt     = rev_r ? (~q_r + FRACTION_BITS'(1)) : q_r;
          acc_nxt   = '0;
          cnt_nxt   = CW'(FRACTION_BITS);
          state_nxt = U_MUL;
        end
      end
      U_MUL: begin
        op_a    = {acc_r, 1'b0};
        op_b    = q_r[FRACTION_BITS-1] ? {{(AW-DW){diff_r[DW-1]}}, diff_r} : '0;
        acc_nxt = sum[PW-1:0];
        q_nxt   = {q_r[FRACTION_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = U_ADD;
        end
      end
      U_ADD: begin
        op_a      = {{(AW-DW){acc_r[PW-1]}}, acc_r[PW-1:FRACTION_BITS]};
        op_b      = {{(AW-VALUE_BITS){sv_r[VALUE_BITS-1]}}, sv_r};
        value_nxt = sum[VALUE_BITS-1:0];
        state_nxt = U_DONE;
      end
      U_DONE: begin
        state_nxt = U_IDLE;
      end
      default: begin
        state_nxt = U_IDLE;
      end
    endcase
  end

  assign rsp.done  = (state_r == U_DONE);
  assign rsp.value = value_r;

endmodule

`default_nettype wire

// ----- rtl/core/tween_interpolation_timer.sv -----
// Start, stop, pause, resume and ticks that compute nothing give their item
// in the cycle after accept; a tick still in the delay passes through C_LEAD,
// a tick that ends a pass through C_LEAD and C_SPAN, and an interpolating
// tick also waits in C_WAIT, paced by the shared adder doing one divide
// step and then one multiply step per cycle. One item is in work at a time.
// Reset (synchronous, rst_n low): idle, counters, value and config zero.
`default_nettype none

module tween_interpolation_timer
  import twn_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic signed [VALUE_BITS-1:0] start_r, end_r;
  logic [SPAN_W-1:0]            span_r, lead_r;
  logic signed [REPEAT_W-1:0]   repeat_r;
  logic                         yoyo_r;

  ctl_state_t                   cstate_r, cstate_nxt;
  phase_t                       phase_r, phase_nxt;
  logic [ELAPSED_W-1:0]         elapsed_r, elapsed_nxt;
  logic [PASS_W-1:0]            passes_r, passes_nxt;
  logic                         rev_r, rev_nxt;
  logic signed [VALUE_BITS-1:0] held_r, held_nxt;
  logic [ELAPSED_W-1:0]         active_r, active_nxt;
  out_item_t                    out_r, out_nxt;
  logic                         out_valid_r, out_valid_nxt;

  logic                         in_acc;
  logic                         emit;
  logic                         updated, finished;
  logic [ELAPSED_W:0]           el_sum;
  logic [ELAPSED_W:0]           lead_diff;
  logic                         full;
  logic                         rpt_go;
  arith_req_t                   req;
  arith_rsp_t                   rsp;

  twn_arith #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_arith (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  assign in_stall  = (cstate_r != C_IDLE) || (out_valid_r && out_stall);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign el_sum    = {1'b0, elapsed_r} + {{(ELAPSED_W+1-DELTA_W){1'b0}}, in_data.delta_ms};
  assign lead_diff = {1'b0, elapsed_r} - {{(ELAPSED_W+1-SPAN_W){1'b0}}, lead_r};
  assign full      = (span_r == '0) || (active_r >= {{(ELAPSED_W-SPAN_W){1'b0}}, span_r});
  assign rpt_go    = (&repeat_r) || ($signed({1'b0, passes_r}) < repeat_r);

  assign req.go          = (cstate_r == C_SPAN) && !full;
  assign req.active      = active_r[SPAN_W-1:0];
  assign req.span        = span_r;
  assign req.rev         = rev_r;
  assign req.start_value = start_r;
  assign req.end_value   = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      end_r       <= '0;
      span_r      <= '0;
      lead_r      <= '0;
      repeat_r    <= '0;
      yoyo_r      <= 1'b0;
      cstate_r    <= C_IDLE;
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      passes_r    <= '0;
      rev_r       <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_START_VALUE:  start_r  <= cfg_wdata[VALUE_BITS-1:0];
          CFG_END_VALUE:    end_r    <= cfg_wdata[VALUE_BITS-1:0];
          CFG_SPAN_MS:      span_r   <= cfg_wdata[SPAN_W-1:0];
          CFG_LEAD_MS:      lead_r   <= cfg_wdata[SPAN_W-1:0];
          CFG_REPEAT_LIMIT: repeat_r <= cfg_wdata[REPEAT_W-1:0];
          CFG_YOYO_ENABLE:  yoyo_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      cstate_r    <= cstate_nxt;
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      passes_r    <= passes_nxt;
      rev_r       <= rev_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
    active_r <= active_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    cstate_nxt  = cstate_r;
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    passes_nxt  = passes_r;
    rev_nxt     = rev_r;
    held_nxt    = held_r;
    active_nxt  = active_r;
    emit        = 1'b0;
    updated     = 1'b0;
    finished    = 1'b0;

    unique case (cstate_r)
      C_IDLE: begin
        if (in_acc) begin
          emit = 1'b1;
          unique case (in_data.command)
            CMD_START: begin
              held_nxt    = start_r;
              elapsed_nxt = '0;
              passes_nxt  = '0;
              rev_nxt     = 1'b0;
              phase_nxt   = PH_RUN;
            end
            CMD_STOP: begin
              phase_nxt = PH_IDLE;
            end
            CMD_PAUSE: begin
              if (phase_r == PH_RUN) begin
                phase_nxt = PH_PAUSE;
              end
            end
            CMD_RESUME: begin
              if (phase_r == PH_PAUSE) begin
                phase_nxt = PH_RUN;
              end
            end
            CMD_TICK: begin
              if (phase_r == PH_RUN) begin
                emit        = 1'b0;
                elapsed_nxt = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
                cstate_nxt  = C_LEAD;
              end
            end
            default: ;
          endcase
        end
      end
      C_LEAD: begin
        if (lead_diff[ELAPSED_W]) begin
          emit       = 1'b1;
          cstate_nxt = C_IDLE;
        end else begin
          active_nxt = lead_diff[ELAPSED_W-1:0];
          cstate_nxt = C_SPAN;
        end
      end
      C_SPAN: begin
        if (full) begin
          emit     = 1'b1;
          updated  = 1'b1;
          held_nxt = rev_r ? start_r : end_r;
          if (rpt_go) begin
            if (passes_r != '1) begin
              passes_nxt = passes_r + PASS_W'(1);
            end
            elapsed_nxt = {{(ELAPSED_W-SPAN_W){1'b0}}, lead_r};
            rev_nxt     = rev_r ^ yoyo_r;
          end else begin
            phase_nxt = PH_DONE;
            finished  = 1'b1;
          end
          cstate_nxt = C_IDLE;
        end else begin
          cstate_nxt = C_WAIT;
        end
      end
      C_WAIT: begin
        if (rsp.done) begin
          emit       = 1'b1;
          updated    = 1'b1;
          held_nxt   = rsp.value;
          cstate_nxt = C_IDLE;
        end
      end
      default: begin
        cstate_nxt = C_IDLE;
      end
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
    out_nxt       = out_r;
    if (emit) begin
      out_nxt.current_value = held_nxt;
      out_nxt.value_updated = updated;
      out_nxt.still_active  = (phase_nxt == PH_RUN) || (phase_nxt == PH_PAUSE);
      out_nxt.run_state     = phase_nxt;
      out_nxt.just_finished = finished;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/twn_checker.sv -----
`default_nettype none

module twn_checker
  import twn_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid || in_stall)
    else $error("accepted item left neither a result nor a busy block");

  a_active_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.still_active ==
      ((out_data.run_state == PH_RUN) || (out_data.run_state == PH_PAUSE)))
    else $error("still_active disagrees with run_state");

  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.just_finished |->
      out_data.run_state == PH_DONE && out_data.value_updated)
    else $error("finish reported without completion and update");

  a_update_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.value_updated |->
      (out_data.run_state == PH_RUN) || (out_data.run_state == PH_DONE))
    else $error("value updated outside a running tween");

endmodule

bind tween_interpolation_timer twn_checker u_twn_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

`default_nettype wire
